[rtl/rgbf_pkg.sv]
// rgbf_pkg: shared constants, status codes and helper functions for the
// rgb led command pwm fader; used by the interfaces and the top level
`default_nettype none

package rgbf_pkg;

    localparam int LED_COUNT = 3;
    // number of drive outputs that map onto existing leds
    localparam int DRIVE_N   = (LED_COUNT < 3) ? LED_COUNT : 3;

    localparam int STATUS_W  = 3;
    localparam int LEVEL_W   = 7;
    localparam int DELAY_W   = 32;

    localparam logic [LEVEL_W-1:0] PWM_LAST    = 7'd99;
    localparam logic [LEVEL_W-1:0] FULL_POWER  = 7'd100;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd100000;

    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_TICK      = 3'd0,
        ST_POWER     = 3'd1,
        ST_EFF_ON    = 3'd2,
        ST_EFF_OFF   = 3'd3,
        ST_DELAY     = 3'd4,
        ST_BAD_LED   = 3'd5,
        ST_BAD_BYTE  = 3'd6,
        ST_BAD_DELAY = 3'd7
    } status_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] led_letter;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
    } cmd_item_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // ten to the power e, e in 0..9
    function automatic logic [DELAY_W-1:0] pow10(input logic [3:0] e);
        logic [DELAY_W-1:0] v;
        case (e)
            4'd0:    v = 32'd1;
            4'd1:    v = 32'd10;
            4'd2:    v = 32'd100;
            4'd3:    v = 32'd1000;
            4'd4:    v = 32'd10000;
            4'd5:    v = 32'd100000;
            4'd6:    v = 32'd1000000;
            4'd7:    v = 32'd10000000;
            4'd8:    v = 32'd100000000;
            4'd9:    v = 32'd1000000000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/rgbf_if.sv]
// rgbf_if: valid/ready channel interfaces for command items and results
// depends on rgbf_pkg for field widths
`default_nettype none

interface rgbf_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] led_letter;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;

    modport source (output valid, cmd, led_letter, byte_one, byte_two, byte_three,
                    input ready);
    modport sink   (input valid, cmd, led_letter, byte_one, byte_two, byte_three,
                    output ready);
endinterface

interface rgbf_res_if;
    logic                            valid;
    logic                            ready;
    logic [rgbf_pkg::STATUS_W-1:0]   status;
    logic                            red_on;
    logic                            green_on;
    logic                            blue_on;
    logic [rgbf_pkg::LEVEL_W-1:0]    fade_now;

    modport source (output valid, status, red_on, green_on, blue_on, fade_now,
                    input ready);
    modport sink   (input valid, status, red_on, green_on, blue_on, fade_now,
                    output ready);
endinterface

`default_nettype wire

[rtl/rgb_led_command_pwm_fader_unit.sv]
// rgb_led_command_pwm_fader_unit: command decoder, pwm compare and fade sweep
// depends on rgbf_pkg and the channel interfaces in rgbf_if.sv
// path: a command is held in the input register, then its result in the result register
// throughput: one item per cycle while the result is taken, set by the single
// decode-and-update pass between the input register and the result register
// reset: powers, effects, counters and fade cleared, step delay 100000 ticks
`default_nettype none

module rgb_led_command_pwm_fader_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rgbf_cmd_if.sink   command,
    rgbf_res_if.source result
);
    import rgbf_pkg::*;

    // input stage
    logic      in_valid_reg;
    cmd_item_t in_item_reg;
    logic      advance;

    // block state
    logic [LEVEL_W-1:0] power_reg  [LED_COUNT];
    logic [LEVEL_W-1:0] power_next [LED_COUNT];
    logic [LED_COUNT-1:0] effect_reg, effect_next;
    logic [DELAY_W-1:0] step_delay_reg, step_delay_next;
    logic [DELAY_W-1:0] delay_cnt_reg, delay_cnt_next;
    logic [LEVEL_W-1:0] fade_reg, fade_next;
    logic               falling_reg, falling_next;
    logic [LEVEL_W-1:0] pwm_reg, pwm_next;

    // result stage
    logic               res_valid_reg;
    status_t            status_reg, status_next;
    logic [2:0]         drive_reg, drive_next;
    logic [LEVEL_W-1:0] fade_out_reg;

    // decode helpers
    logic [DELAY_W-1:0]   cnt_inc;
    logic                 sel_all;
    logic [1:0]           sel_idx;
    logic                 letter_ok;
    logic [LED_COUNT-1:0] sel_mask;
    logic [DELAY_W+1:0]   delay_prod;
    logic signed [12:0]   tens_val;
    logic signed [12:0]   units_val;
    logic signed [12:0]   power_sum;
    logic [LEVEL_W-1:0]   power_val;

    assign advance       = in_valid_reg && (!res_valid_reg || result.ready);
    assign command.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (command.ready)
        begin
            in_valid_reg <= command.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (command.valid && command.ready)
        begin
            in_item_reg.cmd        <= command.cmd;
            in_item_reg.led_letter <= command.led_letter;
            in_item_reg.byte_one   <= command.byte_one;
            in_item_reg.byte_two   <= command.byte_two;
            in_item_reg.byte_three <= command.byte_three;
        end
    end

    // letter decode
    always_comb
    begin
        sel_all   = 1'b0;
        sel_idx   = 2'd0;
        letter_ok = 1'b1;
        unique case (in_item_reg.led_letter)
            CH_R:    sel_idx = 2'd0;
            CH_G:    sel_idx = 2'd1;
            CH_B:    sel_idx = 2'd2;
            CH_A:    sel_all = 1'b1;
            default: letter_ok = 1'b0;
        endcase
        if (!sel_all && (int'(sel_idx) >= LED_COUNT))
        begin
            letter_ok = 1'b0;
        end
        for (int k = 0; k < LED_COUNT; k++)
        begin
            sel_mask[k] = sel_all || (int'(sel_idx) == k);
        end
    end

    // delay value and power value
    always_comb
    begin
        delay_prod = (DELAY_W+2)'(in_item_reg.byte_two[3:0])
                   * (DELAY_W+2)'(pow10(in_item_reg.byte_three[3:0]));
        tens_val   = $signed({5'b0, in_item_reg.byte_two}) - 13'sd48;
        units_val  = $signed({5'b0, in_item_reg.byte_three}) - 13'sd48;
        power_sum  = ((in_item_reg.byte_one == CH_ONE) ? 13'sd100 : 13'sd0)
                   + 13'(tens_val * 13'sd10) + units_val;
        if ((power_sum < 13'sd0) || (power_sum > 13'sd100))
        begin
            power_val = FULL_POWER;
        end
        else
        begin
            power_val = power_sum[LEVEL_W-1:0];
        end
    end

    // single pass update
    always_comb
    begin
        power_next      = power_reg;
        effect_next     = effect_reg;
        step_delay_next = step_delay_reg;
        delay_cnt_next  = delay_cnt_reg;
        fade_next       = fade_reg;
        falling_next    = falling_reg;
        pwm_next        = pwm_reg;
        drive_next      = 3'b000;
        status_next     = ST_TICK;
        cnt_inc         = (delay_cnt_reg != '1) ? delay_cnt_reg + 1'b1 : delay_cnt_reg;

        if (in_item_reg.cmd)
        begin
            for (int k = 0; k < DRIVE_N; k++)
            begin
                drive_next[k] = pwm_reg < power_reg[k];
            end
            pwm_next       = (pwm_reg == PWM_LAST) ? '0 : pwm_reg + 1'b1;
            delay_cnt_next = cnt_inc;
            if (cnt_inc >= step_delay_reg)
            begin
                delay_cnt_next = '0;
                // sweep holds each end for one extra step
                if (!falling_reg)
                begin
                    if (fade_reg < FULL_POWER)
                        fade_next = fade_reg + 1'b1;
                    else
                        falling_next = 1'b1;
                end
                else
                begin
                    if (fade_reg != '0)
                        fade_next = fade_reg - 1'b1;
                    else
                        falling_next = 1'b0;
                end
                for (int k = 0; k < LED_COUNT; k++)
                begin
                    if (effect_reg[k])
                        power_next[k] = fade_next;
                end
            end
        end
        else if (!letter_ok)
        begin
            status_next = ST_BAD_LED;
        end
        else if (in_item_reg.byte_one == CH_E)
        begin
            if (in_item_reg.byte_two == CH_N)
            begin
                effect_next = effect_reg | sel_mask;
                status_next = ST_EFF_ON;
            end
            else if (in_item_reg.byte_two == CH_F)
            begin
                effect_next = effect_reg & ~sel_mask;
                status_next = ST_EFF_OFF;
            end
            else if (!is_digit(in_item_reg.byte_two) || !is_digit(in_item_reg.byte_three))
            begin
                status_next = ST_BAD_DELAY;
            end
            else
            begin
                step_delay_next = (delay_prod[DELAY_W+1:DELAY_W] != 2'b00)
                                ? '1 : delay_prod[DELAY_W-1:0];
                status_next     = ST_DELAY;
            end
        end
        else if ((in_item_reg.byte_one == CH_ZERO) || (in_item_reg.byte_one == CH_ONE))
        begin
            for (int k = 0; k < LED_COUNT; k++)
            begin
                if (sel_mask[k])
                    power_next[k] = power_val;
            end
            status_next = ST_POWER;
        end
        else
        begin
            status_next = ST_BAD_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LED_COUNT; k++)
            begin
                power_reg[k] <= '0;
            end
            effect_reg     <= '0;
            step_delay_reg <= DELAY_RESET;
            delay_cnt_reg  <= '0;
            fade_reg       <= '0;
            falling_reg    <= 1'b0;
            pwm_reg        <= '0;
        end
        else if (advance)
        begin
            power_reg      <= power_next;
            effect_reg     <= effect_next;
            step_delay_reg <= step_delay_next;
            delay_cnt_reg  <= delay_cnt_next;
            fade_reg       <= fade_next;
            falling_reg    <= falling_next;
            pwm_reg        <= pwm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg   <= status_next;
            drive_reg    <= drive_next;
            fade_out_reg <= fade_next;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.status   = status_reg;
    assign result.red_on   = drive_reg[0];
    assign result.green_on = drive_reg[1];
    assign result.blue_on  = drive_reg[2];
    assign result.fade_now = fade_out_reg;

endmodule

`default_nettype wire
